>>> sv/smsb_pkg.sv
`default_nettype none

package smsb_pkg;

  // Geometry of the matrix
  localparam int ROWS_DEFAULT = 16;
  localparam int PAIRS = 8;

  // Item operation codes (code three is unused and ignored)
  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_CALIBRATE = 2'd1,
    OP_RESTART   = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CAL_FRAMES = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_ORIGIN_X   = 2'd2
  } reg_idx_t;

  localparam logic [7:0]  CAL_FRAMES_RESET = 8'd10;
  localparam logic [15:0] DRIVE_LOW        = 16'h0001;
  localparam logic [15:0] DRIVE_HIGH       = 16'h8000;

  // Per-item control word handed from the sequencer to the datapath
  typedef struct packed {
    logic        sample;
    logic        calibrating;
    logic [7:0]  cell_a;
    logic        frame_end;
    logic [15:0] row_drive;
    logic [7:0]  mux_code;
  } item_info_t;

  // Column multiplexer select byte, forward or reversed table
  function automatic logic [7:0] mux_select(input logic fwd, input logic [2:0] pair);
    logic [7:0] code;
    case (pair)
      3'd0:    code = fwd ? 8'h33 : 8'h55;
      3'd1:    code = fwd ? 8'h00 : 8'h77;
      3'd2:    code = fwd ? 8'h11 : 8'h66;
      3'd3:    code = fwd ? 8'h22 : 8'h44;
      3'd4:    code = fwd ? 8'h44 : 8'h22;
      3'd5:    code = fwd ? 8'h66 : 8'h11;
      3'd6:    code = fwd ? 8'h77 : 8'h00;
      3'd7:    code = fwd ? 8'h55 : 8'h33;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> sv/smsb_bank.sv
`default_nettype none

module smsb_bank #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  output logic [7:0]         rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [7:0]       rd_q;
  logic             rd_live;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track entries written since reset; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Registered read, bypass a write to the same entry on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q    <= wr_data;
        rd_live <= 1'b1;
      end else begin
        rd_q    <= mem[rd_addr];
        rd_live <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_live ? rd_q : 8'd0;

endmodule

`default_nettype wire

>>> sv/smsb_scan.sv
`default_nettype none

module smsb_scan #(
  parameter int ROWS = smsb_pkg::ROWS_DEFAULT,
  parameter int AW   = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [1:0]           operation,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  output smsb_pkg::item_info_t      info,
  output logic [AW-1:0]             rd_addr
);

  import smsb_pkg::*;

  localparam int RowW = AW - 3;

  logic [7:0] cal_frames;
  logic       origin_y;
  logic       origin_x;
  logic [3:0] row;
  logic [2:0] pair;
  logic [7:0] cal_left;
  logic [3:0] row_next;
  logic [2:0] pair_next;
  logic [7:0] cal_left_next;
  logic       last_row;
  logic       last_pair;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_frames <= CAL_FRAMES_RESET;
      origin_y   <= 1'b1;
      origin_x   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_FRAMES: cal_frames <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data[0];
        REG_ORIGIN_X:   origin_x   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  assign last_row  = (row == 4'(ROWS - 1));
  assign last_pair = (pair == 3'(PAIRS - 1));

  // Advance the scan position and calibration frame count
  always_comb begin
    row_next      = row;
    pair_next     = pair;
    cal_left_next = cal_left;
    case (operation)
      OP_SAMPLE: begin
        if (last_row) begin
          row_next  = 4'd0;
          pair_next = pair + 3'd1;
          if (last_pair && (cal_left != 8'd0)) begin
            cal_left_next = cal_left - 8'd1;
          end
        end else begin
          row_next = row + 4'd1;
        end
      end
      OP_CALIBRATE: begin
        row_next      = 4'd0;
        pair_next     = 3'd0;
        cal_left_next = cal_frames;
      end
      OP_RESTART: begin
        row_next  = 4'd0;
        pair_next = 3'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= 4'd0;
      pair     <= 3'd0;
      cal_left <= 8'd0;
    end else if (accept) begin
      row      <= row_next;
      pair     <= pair_next;
      cal_left <= cal_left_next;
    end
  end

  // Describe the item being taken in
  always_comb begin
    info.sample      = (operation == OP_SAMPLE);
    info.calibrating = info.sample && (cal_left != 8'd0);
    info.cell_a      = info.sample ? {row, 1'b0, pair} : 8'd0;
    info.frame_end   = info.sample && last_row && last_pair;
    info.row_drive   = origin_y ? (DRIVE_LOW << row_next) : (DRIVE_HIGH >> row_next);
    info.mux_code    = mux_select(origin_x, pair_next);
  end

  assign rd_addr = {row[RowW-1:0], pair};

endmodule

`default_nettype wire

>>> sv/sensor_matrix_scan_baseline_unit.sv
`default_nettype none

// An accepted item passes through the middle stage into the output register. Throughput:
// one item per cycle unless stalled; each baseline bank does one read and one write per
// cycle. Items keep flowing while a result waits, as long as the middle stage is free.
// Reset: scan position, calibration count and valid flags clear, registers take
// their defaults, and every baseline reads as zero until written.
module sensor_matrix_scan_baseline_unit #(
  parameter int ROWS = smsb_pkg::ROWS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] sample_a,
  input  wire logic [7:0] sample_b,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            calibrating,
  output logic [7:0]      cell_a,
  output logic [7:0]      value_a,
  output logic [7:0]      cell_b,
  output logic [7:0]      value_b,
  output logic [15:0]     next_row_drive,
  output logic [7:0]      next_mux_code,
  output logic            frame_end
);

  import smsb_pkg::*;

  localparam int RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = RowW + 3;
  localparam int DEPTH = ROWS * PAIRS;

  item_info_t info;
  item_info_t s1_info;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] s1_addr;
  logic          s1_valid;
  logic [7:0]    s1_sample_a;
  logic [7:0]    s1_sample_b;
  logic          in_accept;
  logic          out_free;
  logic          s1_move;
  logic          wr_en;
  logic [7:0]    base_a;
  logic [7:0]    base_b;
  logic [7:0]    max_a;
  logic [7:0]    max_b;
  logic [7:0]    val_a;
  logic [7:0]    val_b;

  // Handshake between the stages
  assign out_free  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  smsb_scan #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .operation (operation),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info),
    .rd_addr   (rd_addr)
  );

  // Baselines for columns 0..7 and 8..15 live in separate banks
  assign wr_en = s1_move && s1_info.calibrating;

  smsb_bank #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bank_a (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (max_a),
    .rd_data (base_a)
  );

  smsb_bank #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bank_b (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (max_b),
    .rd_data (base_b)
  );

  // Middle stage: hold the item while its baselines are read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_info     <= info;
      s1_addr     <= rd_addr;
      s1_sample_a <= sample_a;
      s1_sample_b <= sample_b;
    end
  end

  // Track the maximum while calibrating, else subtract floored at zero; non-sample items give zero
  assign max_a = (s1_sample_a > base_a) ? s1_sample_a : base_a;
  assign max_b = (s1_sample_b > base_b) ? s1_sample_b : base_b;

  always_comb begin
    val_a = 8'd0;
    val_b = 8'd0;
    if (s1_info.calibrating) begin
      val_a = max_a;
      val_b = max_b;
    end else if (s1_info.sample) begin
      val_a = (s1_sample_a > base_a) ? (s1_sample_a - base_a) : 8'd0;
      val_b = (s1_sample_b > base_b) ? (s1_sample_b - base_b) : 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      calibrating    <= s1_info.calibrating;
      cell_a         <= s1_info.cell_a;
      cell_b         <= s1_info.sample ? (s1_info.cell_a + 8'd8) : 8'd0;
      value_a        <= val_a;
      value_b        <= val_b;
      next_row_drive <= s1_info.row_drive;
      next_mux_code  <= s1_info.mux_code;
      frame_end      <= s1_info.frame_end;
    end
  end

  // A full middle stage behind a stalled result must hold the input back
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while both stages were full");

  // A frame ends only at the last row of the last column pair
  a_frame_end_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> cell_a == {4'(ROWS - 1), 1'b0, 3'(PAIRS - 1)})
    else $error("frame end reported at the wrong cell");

  // Calibration results pair cells eight columns apart
  a_cal_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrating |-> cell_b == cell_a + 8'd8)
    else $error("calibration result with mismatched cell pair");

endmodule

`default_nettype wire
